// ----- hdl/hsm_pkg.sv -----
// ----------------------------------------------------------------------------
// hsm_pkg - shared types and constants of the hash set membership match block
// Holds the table and chunk sizes, the item structs of both channels, the
// request and result codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package hsm_pkg;

	// Table and chunk sizing.
	localparam int TABLE_ENTRIES  = 32;
	localparam int CHUNK_QUERIES  = 32;
	localparam int HASH_BYTES     = 64;
	localparam int WORD_W         = 64;
	localparam int ROW_W          = HASH_BYTES * 8;
	localparam int VALUE_W        = 6;

	// Row address into the table, and counters that can hold the full size.
	localparam int TBL_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int LOAD_W = $clog2(TABLE_ENTRIES + 1);
	localparam int POS_W  = $clog2(CHUNK_QUERIES + 1);

	// Request and result codes.
	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef enum logic {
		KIND_POS   = 1'b0,
		KIND_COUNT = 1'b1
	} rsp_kind_t;

	// Input item.
	typedef struct packed {
		req_kind_t           req_type;
		logic [WORD_W-1:0]   word0;
		logic [WORD_W-1:0]   word1;
		logic [WORD_W-1:0]   word2;
		logic [WORD_W-1:0]   word3;
		logic [WORD_W-1:0]   word4;
		logic [WORD_W-1:0]   word5;
		logic [WORD_W-1:0]   word6;
		logic [WORD_W-1:0]   word7;
		logic                chunk_last;
	} req_t;

	// Result item.
	typedef struct packed {
		rsp_kind_t           result_kind;
		logic [VALUE_W-1:0]  result_value;
		logic                run_last;
	} rsp_t;

	// Status returned by the match unit to the sequencer.
	typedef struct packed {
		logic done;
		logic hit;
	} scan_status_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POS,
		ST_CNT
	} seq_state_t;

	// Gather the eight words of an item into one table row, word 0 lowest.
	function automatic logic [ROW_W-1:0] pack_hash(input req_t r);
		return {r.word7, r.word6, r.word5, r.word4,
			r.word3, r.word2, r.word1, r.word0};
	endfunction

endpackage

// ----- hdl/hash_set_membership_match.sv -----
// ----------------------------------------------------------------------------
// hash_set_membership_match - exact-match table of 512-bit hashes
// Load items append a hash to the table; query items look a hash up and
// report matches per chunk of queries.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the req channel and results leave on the rsp channel, both
// with valid/ready handshakes. A load item is taken and the block is ready
// again straight away; it writes the next free table row, or is dropped when
// the table is full. A query item walks all TABLE_ENTRIES rows through one
// shared comparator, one row per cycle after a registered RAM read; no new
// item is taken until the walk is over and the query's result items are in
// the output register. A matching query yields a position item; the last
// query of a chunk also yields a count item, after the position item.
// Results pass through a single output register. While the receiver stalls,
// the sequencer waits to place its next item and req_ready stays low; a
// waiting result does not stop a following load from being taken.
// Reset empties the table (unloaded rows read as zero), clears the chunk
// counters and drops any result in flight. No clearing pass is needed.
// ----------------------------------------------------------------------------
module hash_set_membership_match (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  hsm_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output hsm_pkg::rsp_t  rsp
);

	import hsm_pkg::*;

	seq_state_t           state_q;
	seq_state_t           state_nxt;
	logic [LOAD_W-1:0]    loaded_q;
	logic [POS_W-1:0]     pos_q;
	logic [POS_W-1:0]     matches_q;
	logic [POS_W-1:0]     qpos_q;
	logic                 last_q;
	logic [ROW_W-1:0]     hash_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic                 accept;
	logic                 is_query;
	logic                 in_range;
	logic                 table_full;
	logic                 wr_en;
	logic                 scan_start;
	logic                 slot_free;
	logic                 rsp_load;
	logic                 chunk_clear;
	rsp_t                 rsp_nxt;
	scan_status_t         status;

	assign accept     = req_valid && req_ready;
	assign is_query   = (req.req_type == REQ_QUERY);
	assign in_range   = pos_q < POS_W'(CHUNK_QUERIES);
	assign table_full = loaded_q >= LOAD_W'(TABLE_ENTRIES);
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign wr_en      = accept && !is_query && !table_full;

	hsm_match_unit u_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (loaded_q[TBL_AW-1:0]),
		.wr_data (pack_hash(req)),
		.loaded  (loaded_q),
		.start   (scan_start),
		.hash    (hash_q),
		.status  (status)
	);

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_query) begin
					if (in_range) begin
						state_nxt = ST_SCAN;
					end else if (req.chunk_last) begin
						state_nxt = ST_CNT;
					end
				end
			end
			ST_SCAN: begin
				if (status.done) begin
					if (status.hit) begin
						state_nxt = ST_POS;
					end else if (last_q) begin
						state_nxt = ST_CNT;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_POS: begin
				if (slot_free) begin
					state_nxt = last_q ? ST_CNT : ST_IDLE;
				end
			end
			ST_CNT: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		req_ready   = 1'b0;
		scan_start  = 1'b0;
		rsp_load    = 1'b0;
		chunk_clear = 1'b0;
		rsp_nxt     = '{result_kind: KIND_POS, result_value: '0, run_last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				req_ready  = 1'b1;
				scan_start = req_valid && is_query && in_range;
			end
			ST_SCAN: begin
			end
			ST_POS: begin
				rsp_load = slot_free;
				rsp_nxt  = '{result_kind: KIND_POS,
					result_value: VALUE_W'(qpos_q), run_last: !last_q};
			end
			ST_CNT: begin
				rsp_load    = slot_free;
				chunk_clear = slot_free;
				rsp_nxt     = '{result_kind: KIND_COUNT,
					result_value: VALUE_W'(matches_q), run_last: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Query details held for the length of the walk.
	always_ff @(posedge clk) begin
		if (accept && is_query) begin
			hash_q <= pack_hash(req);
			qpos_q <= pos_q;
			last_q <= req.chunk_last;
		end
	end

	// Table fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (wr_en) begin
			loaded_q <= loaded_q + 1'b1;
		end
	end

	// Chunk position and match counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			matches_q <= '0;
		end else if (chunk_clear) begin
			pos_q     <= '0;
			matches_q <= '0;
		end else if (status.done) begin
			pos_q     <= pos_q + 1'b1;
			matches_q <= matches_q + POS_W'(status.hit);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/hsm_ram.sv -----
// ----------------------------------------------------------------------------
// hsm_ram - generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hdl/hsm_match_unit.sv -----
// ----------------------------------------------------------------------------
// hsm_match_unit - table store and shared row comparator
// Holds the table in a RAM and, once started, walks every row one per cycle
// through a single 512-bit equality compare, collecting a hit flag.
// ----------------------------------------------------------------------------
module hsm_match_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [hsm_pkg::TBL_AW-1:0]  wr_addr,
	input  logic [hsm_pkg::ROW_W-1:0]   wr_data,
	input  logic [hsm_pkg::LOAD_W-1:0]  loaded,
	input  logic                        start,
	input  logic [hsm_pkg::ROW_W-1:0]   hash,
	output hsm_pkg::scan_status_t       status
);

	import hsm_pkg::*;

	localparam logic [TBL_AW-1:0] LAST_ROW = TBL_AW'(TABLE_ENTRIES - 1);

	logic                issue_q;
	logic [TBL_AW-1:0]   idx_q;
	logic                cmp_vld_s1;
	logic                cmp_last_s1;
	logic [TBL_AW-1:0]   cmp_idx_s1;
	logic                hit_q;
	logic [ROW_W-1:0]    rd_data;
	logic [ROW_W-1:0]    row;
	logic                row_valid;
	logic                row_match;

	hsm_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (issue_q),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// Address issue: one row read per cycle from row 0 up to the last row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			idx_q   <= '0;
		end else if (start) begin
			issue_q <= 1'b1;
			idx_q   <= '0;
		end else if (issue_q) begin
			if (idx_q == LAST_ROW) begin
				issue_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Compare stage follows the read in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1  <= 1'b0;
			cmp_last_s1 <= 1'b0;
		end else begin
			cmp_vld_s1  <= issue_q;
			cmp_last_s1 <= issue_q && (idx_q == LAST_ROW);
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
	end

	// Rows never loaded are read as zero.
	assign row_valid = LOAD_W'(cmp_idx_s1) < loaded;
	assign row       = row_valid ? rd_data : '0;
	assign row_match = (row == hash);

	// Hit accumulator over the whole walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (start) begin
			hit_q <= 1'b0;
		end else if (cmp_vld_s1) begin
			hit_q <= hit_q | row_match;
		end
	end

	assign status.done = cmp_vld_s1 && cmp_last_s1;
	assign status.hit  = hit_q | (cmp_vld_s1 && row_match);

endmodule

// ----- hdl/hsm_checker.sv -----
// ----------------------------------------------------------------------------
// hsm_checker - port-level checks for the hash set membership match block
// Watches the top-level channels and flags behaviour the design must never
// show; attached to the top level by the bind statement below.
// ----------------------------------------------------------------------------
module hsm_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_ready,
	input  hsm_pkg::req_t  req,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  hsm_pkg::rsp_t  rsp
);

	import hsm_pkg::*;

	// A stalled result item holds its place and value.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result item changed or vanished while stalled");

	// The last query of a chunk always keeps the block busy for a while,
	// either for its table walk or for its count item.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_QUERY && req.chunk_last
		|=> !req_ready)
		else $error("block ready again straight after the last query of a chunk");

	// A load item leaves the block ready and causes no result.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_LOAD && !rsp_valid
		|=> req_ready && !rsp_valid)
		else $error("load item produced a result or stalled the input");

	// A count item always closes the results of its query.
	a_count_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_kind == KIND_COUNT |-> rsp.run_last)
		else $error("count item not marked as the last result");

endmodule

bind hash_set_membership_match hsm_checker u_hsm_checker (.*);

// ----- tb/tb_hash_set_membership_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_set_membership_match - self-checking testbench of the hash match table
// Loads and queries 512-bit hashes through the valid/ready request channel and
// checks every result item against a predictor of the table and chunk
// counters. The test drives a directed opening, a table fill with overflow, an
// over-long chunk and a long random run, with both sides stalling at random.
// ----------------------------------------------------------------------------
module tb_hash_set_membership_match;
	import hsm_pkg::*;

	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_ITEMS   = 850;
	localparam int HOLD_AT_RESULT = 40;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;

	// Handy hash patterns for the directed part.
	localparam logic [ROW_W-1:0] HASH_ZERO = '0;
	localparam logic [ROW_W-1:0] HASH_ONES = '1;
	localparam logic [ROW_W-1:0] HASH_TOP  = {1'b1, {(ROW_W-1){1'b0}}};
	localparam logic [ROW_W-1:0] HASH_LOWB = {{(ROW_W-8){1'b0}}, 8'hFF};
	localparam logic [ROW_W-1:0] HASH_B80  = {(ROW_W/8){8'h80}};
	localparam logic [ROW_W-1:0] HASH_B7F  = {(ROW_W/8){8'h7F}};

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Items waiting to be offered, and result items still to arrive.
	req_t hash_requests_q[$];
	rsp_t lookup_results_q[$];

	// Predictor state: table rows and chunk counters.
	logic [ROW_W-1:0] table_rows [TABLE_ENTRIES];
	int rows_loaded;
	int chunk_pos;
	int chunk_hits;

	// Progress counters, updated at the clock edge.
	int items_sent        = 0;
	int results_predicted = 0;
	int results_seen      = 0;
	int quiet_cycles      = 0;
	int mismatches        = 0;
	int phase_cut1        = 0;
	int phase_cut2        = 0;
	int idle_phase;
	bit stim_ready        = 1'b0;
	int hold_left         = 0;
	bit hold_done         = 1'b0;

	// What the run went through.
	int n_loads, n_dropped, n_queries, n_hits, n_beyond, n_counts;

	// Generator bookkeeping: hashes held in the table and hashes dropped.
	logic [ROW_W-1:0] gen_rows[$];
	logic [ROW_W-1:0] gen_dropped[$];
	int random_budget;

	hash_set_membership_match i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The run is split into three idling phases by the number of items sent.
	always_comb begin
		if (items_sent < phase_cut1)
			idle_phase = 0;
		else if (items_sent < phase_cut2)
			idle_phase = 1;
		else
			idle_phase = 2;
	end

	function automatic int send_idle_pct(input int ph);
		return (ph == 0) ? 25 : (ph == 1) ? 78 : 0;
	endfunction

	function automatic int recv_idle_pct(input int ph);
		return (ph == 0) ? 78 : (ph == 1) ? 25 : 0;
	endfunction

	function automatic logic [ROW_W-1:0] hash_of(input req_t it);
		return {it.word7, it.word6, it.word5, it.word4,
			it.word3, it.word2, it.word1, it.word0};
	endfunction

	// Predict the result items of one accepted item and queue them.
	function automatic int predict_lookup(input req_t it);
		logic [ROW_W-1:0] key;
		rsp_t res;
		bit   hit;
		int   made;
		key  = hash_of(it);
		hit  = 1'b0;
		made = 0;
		if (it.req_type == REQ_LOAD) begin
			if (rows_loaded < TABLE_ENTRIES) begin
				table_rows[rows_loaded] = key;
				rows_loaded++;
				n_loads++;
			end else begin
				n_dropped++;
			end
			return 0;
		end
		n_queries++;
		if (chunk_pos < CHUNK_QUERIES) begin
			// Every row takes part, rows never loaded included.
			for (int e = 0; e < TABLE_ENTRIES; e++)
				if (table_rows[e] == key)
					hit = 1'b1;
			if (hit) begin
				res.result_kind  = KIND_POS;
				res.result_value = chunk_pos[VALUE_W-1:0];
				res.run_last     = !it.chunk_last;
				lookup_results_q.push_back(res);
				made++;
				chunk_hits++;
				n_hits++;
			end
			chunk_pos++;
		end else begin
			n_beyond++;
		end
		if (it.chunk_last) begin
			res.result_kind  = KIND_COUNT;
			res.result_value = chunk_hits[VALUE_W-1:0];
			res.run_last     = 1'b1;
			lookup_results_q.push_back(res);
			made++;
			n_counts++;
			chunk_pos  = 0;
			chunk_hits = 0;
		end
		return made;
	endfunction

	task automatic report_mismatch(input string what, input rsp_t want, input rsp_t got);
		if (mismatches < REPORT_LIMIT)
			$display("ERROR %s: expected kind=%0d value=%0d last=%0d, got kind=%0d value=%0d last=%0d",
				what, want.result_kind, want.result_value, want.run_last,
				got.result_kind, got.result_value, got.run_last);
		mismatches++;
	endtask

	// Stimulus helpers.
	function automatic logic [ROW_W-1:0] random_hash(input bit extreme);
		logic [ROW_W-1:0] h;
		for (int b = 0; b < ROW_W / 8; b++) begin
			if (extreme) begin
				case ($urandom_range(0, 3))
					0: h[b*8 +: 8] = 8'h00;
					1: h[b*8 +: 8] = 8'hFF;
					2: h[b*8 +: 8] = 8'h7F;
					default: h[b*8 +: 8] = 8'h80;
				endcase
			end else begin
				h[b*8 +: 8] = 8'($urandom_range(0, 255));
			end
		end
		return h;
	endfunction

	task automatic add_item(input req_kind_t kind, input logic [ROW_W-1:0] h, input logic last);
		req_t it;
		it.req_type   = kind;
		it.word0      = h[0*WORD_W +: WORD_W];
		it.word1      = h[1*WORD_W +: WORD_W];
		it.word2      = h[2*WORD_W +: WORD_W];
		it.word3      = h[3*WORD_W +: WORD_W];
		it.word4      = h[4*WORD_W +: WORD_W];
		it.word5      = h[5*WORD_W +: WORD_W];
		it.word6      = h[6*WORD_W +: WORD_W];
		it.word7      = h[7*WORD_W +: WORD_W];
		it.chunk_last = last;
		hash_requests_q.push_back(it);
		if (kind == REQ_LOAD) begin
			if (gen_rows.size() < TABLE_ENTRIES)
				gen_rows.push_back(h);
			else
				gen_dropped.push_back(h);
		end
	endtask

	// Pick a query hash: mostly stored hashes, with near misses and noise.
	function automatic logic [ROW_W-1:0] pick_query_hash();
		logic [ROW_W-1:0] h;
		int pick;
		int bit_idx;
		pick = $urandom_range(0, 99);
		if (pick < 55 && gen_rows.size() != 0) begin
			h = gen_rows[$urandom_range(0, gen_rows.size() - 1)];
		end else if (pick < 70 && gen_rows.size() != 0) begin
			h = gen_rows[$urandom_range(0, gen_rows.size() - 1)];
			bit_idx = $urandom_range(0, ROW_W - 1);
			h[bit_idx] = ~h[bit_idx];
		end else if (pick < 80) begin
			h = HASH_ZERO;
		end else if (pick < 90 && gen_dropped.size() != 0) begin
			h = gen_dropped[$urandom_range(0, gen_dropped.size() - 1)];
		end else begin
			h = random_hash($urandom_range(0, 2) == 0);
		end
		return h;
	endfunction

	// Driver: offers the next pending item, holding it until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req        <= '0;
			items_sent <= 0;
		end else if (!req_valid || req_ready) begin
			if (stim_ready && hash_requests_q.size() != 0 &&
			    ((items_sent != phase_cut1 && items_sent != phase_cut2) ||
			     (!req_valid && results_predicted == results_seen)) &&
			    $urandom_range(0, 99) >= send_idle_pct(idle_phase)) begin
				req_valid  <= 1'b1;
				req        <= hash_requests_q.pop_front();
				items_sent <= items_sent + 1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
			rsp_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct(idle_phase));
		end
	end

	// Monitor: checks each result item, then predicts from each accepted item.
	always @(posedge clk) begin : scoreboard
		rsp_t want;
		int   made;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				results_seen <= results_seen + 1;
				if (lookup_results_q.size() == 0) begin
					report_mismatch("unexpected result", '0, rsp);
				end else begin
					want = lookup_results_q.pop_front();
					if (rsp.result_kind !== want.result_kind ||
					    rsp.result_value !== want.result_value ||
					    rsp.run_last !== want.run_last)
						report_mismatch("wrong result", want, rsp);
				end
			end
			if (req_valid && req_ready) begin
				made = predict_lookup(req);
				results_predicted <= results_predicted + made;
			end
		end
	end

	// Watchdog: cycles in a row with nothing accepted on either channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("ERROR: no item accepted for %0d cycles", WATCHDOG_LIMIT);
		$display("hash_set_membership_match: mismatch");
		$finish;
	end

	// Stimulus, reset and end of run.
	initial begin
		int chunk_len;
		logic [ROW_W-1:0] h;

		for (int e = 0; e < TABLE_ENTRIES; e++)
			table_rows[e] = '0;
		rows_loaded = 0;
		chunk_pos   = 0;
		chunk_hits  = 0;
		n_loads   = 0;
		n_dropped = 0;
		n_queries = 0;
		n_hits    = 0;
		n_beyond  = 0;
		n_counts  = 0;

		// Directed: zero hash hits the empty table, extremes, byte order,
		// bytes either side of the sign boundary, and chunk_last on a load.
		add_item(REQ_QUERY, HASH_ZERO, 1'b0);
		add_item(REQ_QUERY, HASH_ONES, 1'b1);
		add_item(REQ_LOAD, HASH_ONES, 1'b1);
		add_item(REQ_LOAD, HASH_TOP, 1'b0);
		add_item(REQ_LOAD, HASH_LOWB, 1'b0);
		add_item(REQ_LOAD, HASH_B80, 1'b0);
		add_item(REQ_QUERY, HASH_ONES, 1'b0);
		add_item(REQ_QUERY, HASH_TOP, 1'b0);
		add_item(REQ_QUERY, HASH_LOWB, 1'b0);
		add_item(REQ_QUERY, HASH_B80, 1'b0);
		add_item(REQ_QUERY, HASH_B7F, 1'b0);
		add_item(REQ_QUERY, HASH_ONES ^ HASH_LOWB, 1'b0);
		add_item(REQ_QUERY, HASH_TOP | 1, 1'b0);
		add_item(REQ_QUERY, HASH_LOWB << 8, 1'b0);
		add_item(REQ_QUERY, HASH_ZERO, 1'b0);
		add_item(REQ_QUERY, random_hash(1'b0), 1'b1);
		add_item(REQ_QUERY, HASH_ONES, 1'b1);
		add_item(REQ_QUERY, random_hash(1'b1), 1'b0);
		add_item(REQ_QUERY, random_hash(1'b0), 1'b1);

		// Fill the table, including a zero hash and a duplicate.
		random_budget = 0;
		add_item(REQ_LOAD, HASH_ZERO, 1'b0);
		add_item(REQ_LOAD, HASH_B80, 1'($urandom_range(0, 1)));
		random_budget += 2;
		while (gen_rows.size() < TABLE_ENTRIES) begin
			add_item(REQ_LOAD, random_hash($urandom_range(0, 3) == 0),
				1'($urandom_range(0, 1)));
			random_budget++;
		end

		// Loads on a full table are dropped; query one of them later.
		for (int i = 0; i < 3; i++)
			add_item(REQ_LOAD, random_hash(1'b0), 1'($urandom_range(0, 1)));
		add_item(REQ_QUERY, gen_dropped[0], 1'b1);
		random_budget++;

		// An all-hit chunk that runs past the chunk size.
		for (int q = 0; q < CHUNK_QUERIES + 4; q++)
			add_item(REQ_QUERY, gen_rows[$urandom_range(0, gen_rows.size() - 1)],
				q == CHUNK_QUERIES + 3);
		random_budget += CHUNK_QUERIES + 4;

		// Random chunks of queries, with dropped loads as noise.
		while (random_budget < RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 4) begin
				h = ($urandom_range(0, 1) == 0) ? random_hash(1'b0) :
					gen_rows[$urandom_range(0, gen_rows.size() - 1)];
				add_item(REQ_LOAD, h, 1'($urandom_range(0, 1)));
			end else begin
				chunk_len = ($urandom_range(0, 9) == 0) ?
					$urandom_range(CHUNK_QUERIES + 1, CHUNK_QUERIES + 8) :
					$urandom_range(1, CHUNK_QUERIES);
				for (int q = 0; q < chunk_len; q++) begin
					add_item(REQ_QUERY, pick_query_hash(), q == chunk_len - 1);
					random_budget++;
				end
			end
		end

		phase_cut1 = hash_requests_q.size() / 3;
		phase_cut2 = 2 * hash_requests_q.size() / 3;
		stim_ready = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (hash_requests_q.size() != 0 || req_valid ||
		       results_predicted != results_seen);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d loads taken and %0d dropped on a full table, %0d queries.",
			n_loads, n_dropped, n_queries);
		$display("Saw %0d hits, %0d chunk counts and %0d queries past the chunk size.",
			n_hits, n_counts, n_beyond);
		if (mismatches == 0 && lookup_results_q.size() == 0 &&
		    results_predicted == results_seen) begin
			$display("hash_set_membership_match: match");
		end else begin
			$display("ERROR: %0d mismatches, %0d results outstanding",
				mismatches, lookup_results_q.size());
			$display("hash_set_membership_match: mismatch");
		end
		$finish;
	end

endmodule

// ----- hash_set_membership_match.f -----
hdl/hsm_pkg.sv
hdl/hsm_ram.sv
hdl/hsm_match_unit.sv
hdl/hash_set_membership_match.sv
hdl/hsm_checker.sv
tb/tb_hash_set_membership_match.sv
